// ----- src/tcbh_pkg.sv -----
`timescale 1ns / 1ps

package tcbh_pkg;

	localparam int KEY_W      = 32;
	localparam int VAL_W      = 8;
	localparam int CMD_W      = 2;
	localparam int ROW2_SHIFT = 16;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

endpackage

// ----- src/tcbh_ram.sv -----
`timescale 1ns / 1ps

module tcbh_ram #(
	parameter int WIDTH = 164,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- src/tcbh_row_scan.sv -----
`timescale 1ns / 1ps

module tcbh_row_scan #(
	parameter int SLOTS = 4
) (
	input  tcbh_pkg::slot_t [SLOTS-1:0]  row,
	input  logic [tcbh_pkg::KEY_W-1:0]   key,
	output logic [SLOTS-1:0]             hit_oh,
	output logic [SLOTS-1:0]             free_oh
);

	logic [SLOTS-1:0] hit_vec;
	logic [SLOTS-1:0] free_vec;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			hit_vec[s]  = row[s].valid && (row[s].key == key);
			free_vec[s] = !row[s].valid;
		end
	end

	// keep only the lowest set bit
	assign hit_oh  = hit_vec & (~hit_vec + SLOTS'(1));
	assign free_oh = free_vec & (~free_vec + SLOTS'(1));

endmodule

// ----- src/two_choice_bucket_hash_table.sv -----
`timescale 1ns / 1ps

// Two-choice bucketized key/value table. A key may live in row (key & (ROWS-1)) or in
// row ((key >> 16) & (ROWS-1)); each row holds SLOTS slots and one row is one word of a
// dual-read, single-write memory. A transaction first reads both candidate rows, then
// searches them, answers and writes the modified row back. A new transaction is accepted
// while the previous result still waits at the output, but it completes only once the
// output register is free. After reset the block sweeps the memory once to clear the
// valid bits, one row per cycle, and req_stall stays high until the sweep is done.
// cmd 0 looks up, 1 inserts or updates, 2 removes; cmd 3 answers ok = 0 and changes
// nothing. found_value is nonzero only on a lookup hit.
module two_choice_bucket_hash_table #(
	parameter int ROWS  = 1024,
	parameter int SLOTS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [tcbh_pkg::CMD_W-1:0]   cmd,
	input  logic [tcbh_pkg::KEY_W-1:0]   key,
	input  logic [tcbh_pkg::VAL_W-1:0]   new_value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic                         ok,
	output logic [tcbh_pkg::VAL_W-1:0]   found_value
);

	localparam int RW    = $clog2(ROWS);
	localparam int ROW_W = SLOTS * $bits(tcbh_pkg::slot_t);
	localparam logic [RW-1:0] ROW_MASK = RW'(ROWS - 1);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL} state_t;

	state_t                       state_q;
	logic [RW-1:0]                clr_q;
	logic [tcbh_pkg::CMD_W-1:0]   cmd_q;
	logic [tcbh_pkg::KEY_W-1:0]   key_q;
	logic [tcbh_pkg::VAL_W-1:0]   val_q;
	logic                         out_valid_q;
	logic                         ok_q;
	logic [tcbh_pkg::VAL_W-1:0]   found_q;

	logic [tcbh_pkg::KEY_W-1:0]   rd_key;
	logic [tcbh_pkg::KEY_W-1:0]   key_hi;
	logic [RW-1:0]                row1_addr;
	logic [RW-1:0]                row2_addr;
	logic [ROW_W-1:0]             rdata1;
	logic [ROW_W-1:0]             rdata2;
	tcbh_pkg::slot_t [SLOTS-1:0]  row1;
	tcbh_pkg::slot_t [SLOTS-1:0]  row2;
	logic [SLOTS-1:0]             hit1_oh;
	logic [SLOTS-1:0]             hit2_oh;
	logic [SLOTS-1:0]             free1_oh;
	logic [SLOTS-1:0]             free2_oh;

	logic                         accept;
	logic                         finish;
	logic                         res_ok;
	logic [tcbh_pkg::VAL_W-1:0]   res_val;
	logic                         use_row2;
	logic                         upd_set;
	logic [SLOTS-1:0]             upd_oh;
	tcbh_pkg::slot_t [SLOTS-1:0]  new_row;

	logic                         we;
	logic [RW-1:0]                waddr;
	logic [ROW_W-1:0]             wdata;

	assign req_stall   = (state_q != ST_IDLE);
	assign accept      = req_valid && !req_stall;
	assign finish      = (state_q == ST_EVAL) && (!out_valid_q || !rsp_stall);
	assign rsp_valid   = out_valid_q;
	assign ok          = ok_q;
	assign found_value = found_q;

	// address from the port while idle, from the held key while evaluating
	assign rd_key    = (state_q == ST_IDLE) ? key : key_q;
	assign key_hi    = rd_key >> tcbh_pkg::ROW2_SHIFT;
	assign row1_addr = rd_key[RW-1:0] & ROW_MASK;
	assign row2_addr = key_hi[RW-1:0] & ROW_MASK;

	tcbh_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (row1_addr),
		.rdata_a (rdata1),
		.raddr_b (row2_addr),
		.rdata_b (rdata2)
	);

	assign row1 = rdata1;
	assign row2 = rdata2;

	tcbh_row_scan #(.SLOTS(SLOTS)) u_scan1 (
		.row     (row1),
		.key     (key_q),
		.hit_oh  (hit1_oh),
		.free_oh (free1_oh)
	);

	tcbh_row_scan #(.SLOTS(SLOTS)) u_scan2 (
		.row     (row2),
		.key     (key_q),
		.hit_oh  (hit2_oh),
		.free_oh (free2_oh)
	);

	always_comb begin
		res_ok   = 1'b0;
		res_val  = '0;
		use_row2 = 1'b0;
		upd_set  = 1'b0;
		upd_oh   = '0;
		unique case (cmd_q)
			tcbh_pkg::CMD_LOOKUP: begin
				if (|hit1_oh) begin
					res_ok = 1'b1;
					for (int s = 0; s < SLOTS; s++) begin
						res_val = res_val | (hit1_oh[s] ? row1[s].value : '0);
					end
				end else if (|hit2_oh) begin
					res_ok = 1'b1;
					for (int s = 0; s < SLOTS; s++) begin
						res_val = res_val | (hit2_oh[s] ? row2[s].value : '0);
					end
				end
			end
			tcbh_pkg::CMD_INSERT: begin
				upd_set = 1'b1;
				priority if (|hit1_oh) begin
					res_ok = 1'b1;
					upd_oh = hit1_oh;
				end else if (|hit2_oh) begin
					res_ok   = 1'b1;
					use_row2 = 1'b1;
					upd_oh   = hit2_oh;
				end else if (|free1_oh) begin
					res_ok = 1'b1;
					upd_oh = free1_oh;
				end else if (|free2_oh) begin
					res_ok   = 1'b1;
					use_row2 = 1'b1;
					upd_oh   = free2_oh;
				end else begin
					res_ok = 1'b0;
				end
			end
			tcbh_pkg::CMD_REMOVE: begin
				priority if (|hit1_oh) begin
					res_ok = 1'b1;
					upd_oh = hit1_oh;
				end else if (|hit2_oh) begin
					res_ok   = 1'b1;
					use_row2 = 1'b1;
					upd_oh   = hit2_oh;
				end else begin
					res_ok = 1'b0;
				end
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		new_row = use_row2 ? row2 : row1;
		for (int s = 0; s < SLOTS; s++) begin
			if (upd_oh[s]) begin
				if (upd_set) begin
					new_row[s] = '{valid: 1'b1, key: key_q, value: val_q};
				end else begin
					new_row[s].valid = 1'b0;
				end
			end
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = finish && res_ok && (cmd_q != tcbh_pkg::CMD_LOOKUP);
			waddr = use_row2 ? row2_addr : row1_addr;
			wdata = new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cmd_q       <= '0;
			key_q       <= '0;
			val_q       <= '0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			found_q     <= '0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (rsp_valid && !rsp_stall && !finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + RW'(1);
					if (clr_q == ROW_MASK) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= cmd;
						key_q   <= key;
						val_q   <= new_value;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					// hold the read rows until the output register frees up
					if (finish) begin
						out_valid_q <= 1'b1;
						ok_q        <= res_ok;
						found_q     <= res_val;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rsp_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EVAL))
		else $error("response appeared without an evaluation cycle");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EVAL) && (key_q == $past(key)))
		else $error("accepted transaction not captured for evaluation");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !we)
		else $error("memory write while idle");

	a_lookup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (state_q == ST_EVAL)) |-> (cmd_q != tcbh_pkg::CMD_LOOKUP) && res_ok)
		else $error("write-back on lookup or failed transaction");

	a_onehot_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> $onehot0(upd_oh) && $onehot0(hit1_oh) && $onehot0(free2_oh))
		else $error("slot selection is not one-hot");
`endif

endmodule
